// ----- src/sctc_pkg.sv -----
// Shared types and constants for the sector cache tag controller.
package sctc_pkg;

	localparam int          SECTOR_W  = 32;
	localparam int          COUNT_W   = 8;
	localparam int          POS_W     = 24;
	localparam int          POS_SHIFT = 16;
	localparam logic [31:0] EMPTY_TAG = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_FILL   = 2'd1,
		CMD_INVAL  = 2'd2,
		CMD_INIT   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [SECTOR_W-1:0] first_sector;
		logic [COUNT_W-1:0]  sector_count;
		logic [COUNT_W-1:0]  transfer_fail_index;
		logic                link_ready;
	} item_t;

	typedef struct packed {
		logic                success;
		logic                enabled;
		logic [31:0]         hit_total;
		logic [31:0]         miss_total;
		logic [31:0]         fill_total;
		logic [31:0]         invalidate_total;
		logic [31:0]         sectors_served;
		logic [31:0]         failure_total;
		logic [SECTOR_W-1:0] failed_sector;
		logic [POS_W-1:0]    failed_position;
	} result_t;

	// classified command as handed from the front end to the walker
	typedef struct packed {
		cmd_t                cmd;
		logic [SECTOR_W-1:0] first_sector;
		logic [COUNT_W-1:0]  count;
		logic [COUNT_W-1:0]  fail_idx;
		logic                fail_hit;
		logic                link_ready;
	} job_t;

	typedef struct packed {
		logic                valid;
		logic [SECTOR_W-1:0] tag;
	} tag_entry_t;

endpackage

// ----- src/sctc_front.sv -----
// Front end: accepts items, saturates the count and works out the base slot.
module sctc_front import sctc_pkg::*; #(
	parameter int SLOTS     = 8192,
	parameter int MAX_RANGE = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  item_t                    item,
	input  logic                     boot_clear,
	input  logic                     q_full,
	output logic                     push,
	output job_t                     job,
	output logic [$clog2(SLOTS)-1:0] slot
);

	localparam int          IW      = $clog2(SLOTS);
	localparam int          SH      = SECTOR_W + IW;
	localparam logic [IW:0] SLOTS_W = (IW+1)'(SLOTS);
	// floor(2^SH / SLOTS): the quotient it gives is never high and at most one low
	localparam logic [32:0] RECIP   = 33'((64'd1 << SH) / 64'(SLOTS));

	typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} fstate_t;

	fstate_t             st_q;
	job_t                job_q;
	logic [SECTOR_W-1:0] sec_q;
	logic [48:0]         plo_q;
	logic [48:0]         phi_q;
	logic [SECTOR_W-1:0] quo_q;
	logic [IW:0]         part_q;
	logic [IW-1:0]       rem_q;
	logic [1:0]          step_q;
	logic [64:0]         prod_sum;
	logic [COUNT_W-1:0]  cnt_eff;
	logic                accept;

	assign busy   = (st_q != F_IDLE) || boot_clear;
	assign accept = start && !busy;
	assign push   = (st_q == F_PUSH) && !q_full;
	assign job    = job_q;
	assign slot   = rem_q;

	// sector * RECIP, put together from two 16-bit halves of the sector
	assign prod_sum = {phi_q, 16'd0} + {16'd0, plo_q};

	always_comb begin
		cnt_eff = item.sector_count;
		if (int'(item.sector_count) > MAX_RANGE) begin
			cnt_eff = COUNT_W'(MAX_RANGE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= F_IDLE;
			step_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (accept) begin
						st_q   <= F_MOD;
						step_q <= '0;
					end
				end
				F_MOD: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						st_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						st_q <= F_IDLE;
					end
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	// remainder by reciprocal: partial products, quotient, raw remainder, correction
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.cmd          <= item.cmd;
			job_q.first_sector <= item.first_sector;
			job_q.count        <= cnt_eff;
			job_q.fail_idx     <= item.transfer_fail_index;
			job_q.fail_hit     <= item.transfer_fail_index < cnt_eff;
			job_q.link_ready   <= item.link_ready;
			sec_q              <= item.first_sector;
		end else if (st_q == F_MOD) begin
			case (step_q)
				2'd0: begin
					plo_q <= 49'(sec_q[15:0]) * 49'(RECIP);
					phi_q <= 49'(sec_q[31:16]) * 49'(RECIP);
				end
				2'd1: begin
					quo_q <= SECTOR_W'(prod_sum >> SH);
				end
				2'd2: begin
					// true remainder is below 2 * SLOTS, so the low bits suffice
					part_q <= sec_q[IW:0] - quo_q[IW:0] * SLOTS_W;
				end
				default: begin
					rem_q <= (part_q >= SLOTS_W) ? IW'(part_q - SLOTS_W) : IW'(part_q);
				end
			endcase
		end
	end

endmodule

// ----- src/sctc_queue.sv -----
// Two-entry queue between the front end and the tag walker.
module sctc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] ent_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

// ----- src/sctc_back.sv -----
// Tag walker: owns the tag memory, the enable flag, counters and failure record.
module sctc_back import sctc_pkg::*; #(
	parameter int SLOTS = 8192
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	output logic                     pop,
	input  job_t                     job,
	input  logic [$clog2(SLOTS)-1:0] slot,
	output logic                     boot_clear,
	output logic                     done,
	output result_t                  result
);

	localparam int          IW      = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK} bstate_t;

	tag_entry_t mem [SLOTS];

	bstate_t             st_q;
	job_t                job_q;
	logic [IW-1:0]       k_q;
	logic [SECTOR_W-1:0] s_q;
	logic [COUNT_W-1:0]  i_q;
	logic [IW-1:0]       clr_q;
	logic                boot_q;
	logic                v_s1;
	logic                last_s1;
	logic [SECTOR_W-1:0] s_s1;
	logic [IW-1:0]       k_s1;
	tag_entry_t          rd_q;
	logic                cache_on_q;
	logic [31:0]         hit_q, miss_q, fill_q, inval_q, secs_q, fail_q;
	logic [SECTOR_W-1:0] rec_sector_q;
	logic [POS_W-1:0]    rec_pos_q;
	logic                done_q;
	logic                success_q;

	logic                match;
	logic [IW-1:0]       k_next;
	logic                fill_wr;
	logic                inval_wr;
	logic                mem_we;
	logic [IW-1:0]       mem_wa;
	tag_entry_t          mem_wd;

	assign pop        = (st_q == ST_IDLE) && !q_empty;
	assign boot_clear = boot_q;
	assign done       = done_q;

	assign match    = rd_q.valid && (rd_q.tag == s_s1);
	assign k_next   = (k_q == LAST_SLOT) ? '0 : k_q + IW'(1);
	assign fill_wr  = (st_q == ST_WALK) && (job_q.cmd == CMD_FILL) && (i_q != job_q.fail_idx);
	assign inval_wr = (st_q == ST_WALK) && (job_q.cmd == CMD_INVAL) && v_s1 && match;

	always_comb begin
		mem_we = (st_q == ST_CLEAR) || fill_wr || inval_wr;
		mem_wa = k_s1;
		mem_wd = '{valid: 1'b0, tag: EMPTY_TAG};
		if (st_q == ST_CLEAR) begin
			mem_wa = clr_q;
		end else if (fill_wr) begin
			mem_wa = k_q;
			mem_wd = '{valid: 1'b1, tag: s_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			boot_q       <= 1'b1;
			clr_q        <= '0;
			k_q          <= '0;
			s_q          <= '0;
			i_q          <= '0;
			v_s1         <= 1'b0;
			last_s1      <= 1'b0;
			s_s1         <= '0;
			k_s1         <= '0;
			cache_on_q   <= 1'b0;
			hit_q        <= '0;
			miss_q       <= '0;
			fill_q       <= '0;
			inval_q      <= '0;
			secs_q       <= '0;
			fail_q       <= '0;
			rec_sector_q <= '0;
			rec_pos_q    <= '0;
			done_q       <= 1'b0;
			success_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			success_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_SLOT) begin
						st_q   <= ST_IDLE;
						boot_q <= 1'b0;
						if (!boot_q) begin
							cache_on_q <= job_q.link_ready;
							done_q     <= 1'b1;
						end
					end
				end
				ST_IDLE: begin
					if (pop) begin
						k_q  <= slot;
						s_q  <= job.first_sector;
						i_q  <= '0;
						v_s1 <= 1'b0;
						if (job.cmd == CMD_INIT) begin
							st_q  <= ST_CLEAR;
							clr_q <= '0;
						end else if (!cache_on_q) begin
							done_q <= 1'b1;
						end else if (job.count == '0) begin
							if (job.cmd == CMD_INVAL) begin
								inval_q <= inval_q + 32'd1;
							end
							done_q <= 1'b1;
						end else begin
							st_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (job_q.cmd == CMD_FILL) begin
						// one tag written a cycle; stop at the failing sector
						if (i_q == job_q.fail_idx) begin
							fail_q       <= fail_q + 32'd1;
							rec_sector_q <= s_q;
							rec_pos_q    <= (POS_W'(job_q.count) << POS_SHIFT) | POS_W'(i_q);
							cache_on_q   <= 1'b0;
							done_q       <= 1'b1;
							st_q         <= ST_IDLE;
						end else if (i_q == job_q.count - COUNT_W'(1)) begin
							fill_q <= fill_q + 32'd1;
							done_q <= 1'b1;
							st_q   <= ST_IDLE;
						end else begin
							i_q <= i_q + COUNT_W'(1);
							s_q <= s_q + 32'd1;
							k_q <= k_next;
						end
					end else begin
						// read issue side
						if (i_q != job_q.count) begin
							v_s1    <= 1'b1;
							s_s1    <= s_q;
							k_s1    <= k_q;
							last_s1 <= (i_q == job_q.count - COUNT_W'(1));
							i_q     <= i_q + COUNT_W'(1);
							s_q     <= s_q + 32'd1;
							k_q     <= k_next;
						end else begin
							v_s1 <= 1'b0;
						end
						// compare side, on the read issued the cycle before
						if (v_s1) begin
							if ((job_q.cmd == CMD_LOOKUP) && !match) begin
								miss_q <= miss_q + 32'd1;
								done_q <= 1'b1;
								v_s1   <= 1'b0;
								st_q   <= ST_IDLE;
							end else if (last_s1) begin
								if (job_q.cmd == CMD_INVAL) begin
									inval_q <= inval_q + 32'd1;
								end else if (job_q.fail_hit) begin
									fail_q     <= fail_q + 32'd1;
									cache_on_q <= 1'b0;
								end else begin
									hit_q     <= hit_q + 32'd1;
									secs_q    <= secs_q + 32'(job_q.count);
									success_q <= 1'b1;
								end
								done_q <= 1'b1;
								v_s1   <= 1'b0;
								st_q   <= ST_IDLE;
							end
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign result.success          = success_q;
	assign result.enabled          = cache_on_q;
	assign result.hit_total        = hit_q;
	assign result.miss_total       = miss_q;
	assign result.fill_total       = fill_q;
	assign result.invalidate_total = inval_q;
	assign result.sectors_served   = secs_q;
	assign result.failure_total    = fail_q;
	assign result.failed_sector    = rec_sector_q;
	assign result.failed_position  = rec_pos_q;

endmodule

// ----- src/sector_cache_tag_controller_top.sv -----
// Top level of the direct-mapped sector cache tag controller.
//
// An item is taken on a rising edge with start high and busy low; exactly one
// result comes back per item, on result for a single cycle with done high, and
// the receiver cannot hold it off. Results leave in the order the items came
// in. After reset the tag memory is swept empty, one slot a cycle, and busy
// stays high until the sweep is over, so no item can go in before then. The
// front end works out the base slot (a reciprocal multiply and one correcting
// subtract for the remainder by SLOTS) and then parks the item in a two-entry
// queue, waiting while the queue is full; busy is high whenever the front end
// holds an item, so it takes no new item until the last one is parked, and the
// next item is taken while the walker is still busy with earlier ones. In the
// walker a lookup or invalidate walks one tag a cycle through the single
// memory read port (a lookup stops at the first missing sector), a fill writes
// one tag a cycle (stopping early when a burst fails), a command that changes
// nothing (cache off, zero count) is answered without a walk, and init sweeps
// the whole memory. The count is saturated to MAX_RANGE.
module sector_cache_tag_controller_top import sctc_pkg::*; #(
	parameter int SLOTS     = 8192,
	parameter int MAX_RANGE = 128
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int IW = $clog2(SLOTS);
	localparam int QW = $bits(job_t) + IW;

	job_t          f_job;
	logic [IW-1:0] f_slot;
	logic          f_push;
	logic          q_full;
	logic          q_empty;
	logic          b_pop;
	logic [QW-1:0] q_rdata;
	job_t          b_job;
	logic [IW-1:0] b_slot;
	logic          boot_clear;

	// classify the item and find its base slot
	sctc_front #(
		.SLOTS     (SLOTS),
		.MAX_RANGE (MAX_RANGE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.boot_clear (boot_clear),
		.q_full     (q_full),
		.push       (f_push),
		.job        (f_job),
		.slot       (f_slot)
	);

	// decouples the remainder unit from the tag walk
	sctc_queue #(
		.W (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  ({f_slot, f_job}),
		.pop    (b_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_slot, b_job} = q_rdata;

	// walk the tags, keep the counters, issue the result
	sctc_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.pop        (b_pop),
		.job        (b_job),
		.slot       (b_slot),
		.boot_clear (boot_clear),
		.done       (done),
		.result     (result)
	);

endmodule
